>>> hw/rtl/sidl_pkg.sv
// ----------------------------------------------------------------------------
// sidl_pkg
// Shared types, codes and helpers for the sorted interval depth lookup.
// ----------------------------------------------------------------------------
`default_nettype none

package sidl_pkg;

  typedef logic [30:0] pos_t;
  typedef logic [23:0] depth_t;
  typedef logic [31:0] sum_t;

  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_APPEND = 2'd1,
    OP_QUERY  = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_ORDER = 2'd2
  } stat_t;

  // One stored junction record
  typedef struct packed {
    pos_t   pos_begin;
    pos_t   pos_end;
    depth_t depth;
  } entry_t;

  // Partial result of one table row, handed from cell to cell
  typedef struct packed {
    logic   valid;
    logic   last;
    logic   hit;
    depth_t exact;
    sum_t   osum;
    sum_t   isum;
  } wave_t;

  function automatic sum_t sat_add(input sum_t a, input sum_t b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? '1 : s[31:0];
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/sidl_cell.sv
// ----------------------------------------------------------------------------
// sidl_cell
// One cell of the lookup chain: owns every CELLS-th record of the table,
// reads one row per cycle and folds its record into the passing wave.
// ----------------------------------------------------------------------------
`default_nettype none

module sidl_cell #(
  parameter int K      = 0,
  parameter int CELL_W = 1,
  parameter int ROW_W  = 1,
  parameter int ROWS   = 1,
  parameter int CNT_W  = 2
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic [CNT_W-1:0]     count,
  input  sidl_pkg::pos_t       q_begin,
  input  sidl_pkg::pos_t       q_end,
  input  logic                 wr_en,
  input  logic [CELL_W-1:0]    wr_cell,
  input  logic [ROW_W-1:0]     wr_row,
  input  sidl_pkg::entry_t     wr_data,
  input  logic [ROW_W-1:0]     row_in,
  output logic [ROW_W-1:0]     row_out,
  input  sidl_pkg::wave_t      wave_in,
  output sidl_pkg::wave_t      wave_out
);
  import sidl_pkg::*;

  localparam int JW    = ROW_W + CELL_W;
  localparam int CMP_W = (JW > CNT_W) ? JW : CNT_W;

  entry_t mem [0:ROWS-1];
  entry_t rd;
  logic   rd_live;
  logic   bm, em;
  wave_t  wave_next;
  logic [JW-1:0] idx;

  assign idx = {row_in, CELL_W'(K)};

  always_ff @(posedge clk) begin
    if (wr_en && wr_cell == CELL_W'(K)) begin
      mem[wr_row] <= wr_data;
    end
    rd      <= mem[row_in];
    rd_live <= CMP_W'(idx) < CMP_W'(count);
    row_out <= row_in;
  end

  assign bm = rd_live && (rd.pos_begin == q_begin);
  assign em = rd_live && (rd.pos_end == q_end);

  always_comb begin
    wave_next = wave_in;
    if (bm) begin
      wave_next.osum = sat_add(wave_in.osum, sum_t'(rd.depth));
    end
    if (bm && em) begin
      // later records override earlier ones
      wave_next.hit   = 1'b1;
      wave_next.exact = rd.depth;
    end
    if (em) begin
      wave_next.isum = sat_add(wave_in.isum, sum_t'(rd.depth));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wave_out <= '0;
    end else begin
      wave_out <= wave_next;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/sorted_interval_depth_lookup.sv
// ----------------------------------------------------------------------------
// sorted_interval_depth_lookup
// Junction table with append, clear and (start, end) depth query.
// ----------------------------------------------------------------------------
// Input stream: s_tuser carries the operation (clear, append, query), s_tdata
// the start, end and depth. Every transfer yields exactly one result transfer
// on the m_ stream (status, exact depth, start sum, end sum, peak, count).
// Clear, append and unused codes need no scan: the result register loads
// on the edge that takes the input. A query scans the whole table: the
// table is split over CELLS cells (128 at the default depth), each holding
// ROWS records; one row enters the chain per cycle and the partial sums
// ripple cell to cell through a register in each cell. The query result
// loads when the last row leaves the chain, and the next item can be taken
// once the block is back in idle.
// One item is in work at a time; s_tready is high only when idle and the
// result register is free or being drained in the same cycle. A stalled
// receiver simply holds the result and blocks further input.
// Reset empties the table (count and peak to zero); stored records are
// not cleared, entries at or above the count are never used.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_interval_depth_lookup #(
  parameter int TABLE_DEPTH = 4096
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [87:0]  s_tdata,   // pos_begin[30:0], pos_end[61:31], depth_in[85:62]
  input  logic [1:0]   s_tuser,   // operation
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [127:0] m_tdata    // status[1:0], exact_depth[25:2], out_sum[57:26],
                                  // in_sum[89:58], max_depth[113:90], entry_count[126:114]
);
  import sidl_pkg::*;

  localparam int IDX_W  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CELL_W = (IDX_W > 7) ? 7 : IDX_W;
  localparam int CELLS  = 1 << CELL_W;
  localparam int ROWS   = (TABLE_DEPTH + CELLS - 1) / CELLS;
  localparam int ROW_W  = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_WAIT
  } state_t;

  state_t             state;
  logic [ROW_W-1:0]   row_cnt;
  logic [CNT_W-1:0]   count, cnt_next;
  depth_t             peak, peak_next;
  pos_t               last_begin;
  pos_t               q_begin, q_end;
  wave_t              seed, acc, fin;
  logic               seed_valid, seed_last;

  op_t                op;
  pos_t               pb, pe;
  depth_t             dv;
  logic               accept, full, order_bad, do_write;
  stat_t              imm_status;
  logic               fin_done;
  logic               res_load;

  logic [ROW_W-1:0]   row_chain  [0:CELLS];
  wave_t              wave_chain [0:CELLS];
  entry_t             wr_data;

  stat_t              o_status;
  depth_t             o_exact, o_max;
  sum_t               o_osum, o_isum;
  logic [12:0]        o_count;

  assign op = op_t'(s_tuser);
  assign pb = s_tdata[30:0];
  assign pe = s_tdata[61:31];
  assign dv = s_tdata[85:62];

  assign s_tready  = (state == S_IDLE) && (!m_tvalid || m_tready);
  assign accept    = s_tvalid && s_tready;
  assign full      = (count == CNT_W'(TABLE_DEPTH));
  assign order_bad = (count != '0) && (pb < last_begin);

  always_comb begin
    imm_status = ST_OK;
    do_write   = 1'b0;
    cnt_next   = count;
    peak_next  = peak;
    unique case (op)
      OP_CLEAR: begin
        cnt_next  = '0;
        peak_next = '0;
      end
      OP_APPEND: begin
        priority if (full) begin
          imm_status = ST_FULL;
        end else if (order_bad) begin
          imm_status = ST_ORDER;
        end else begin
          do_write  = 1'b1;
          cnt_next  = count + CNT_W'(1);
          peak_next = (dv > peak) ? dv : peak;
        end
      end
      OP_QUERY: begin
      end
      default: begin
      end
    endcase
  end

  assign wr_data = '{pos_begin: pb, pos_end: pe, depth: dv};

  // Chain of cells; rows enter at cell 0, waves leave the last cell in row order
  assign seed = '{valid: seed_valid, last: seed_last, hit: 1'b0, exact: '0,
                  osum: '0, isum: '0};
  assign row_chain[0]  = row_cnt;
  assign wave_chain[0] = seed;

  for (genvar k = 0; k < CELLS; k++) begin : g_cell
    sidl_cell #(
      .K      (k),
      .CELL_W (CELL_W),
      .ROW_W  (ROW_W),
      .ROWS   (ROWS),
      .CNT_W  (CNT_W)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .count    (count),
      .q_begin  (q_begin),
      .q_end    (q_end),
      .wr_en    (accept && do_write),
      .wr_cell  (count[CELL_W-1:0]),
      .wr_row   (ROW_W'(count[IDX_W-1:0] >> CELL_W)),
      .wr_data  (wr_data),
      .row_in   (row_chain[k]),
      .row_out  (row_chain[k+1]),
      .wave_in  (wave_chain[k]),
      .wave_out (wave_chain[k+1])
    );
  end

  // Fold each finished row into the running query result
  always_comb begin
    fin       = acc;
    fin.osum  = sat_add(acc.osum, wave_chain[CELLS].osum);
    fin.isum  = sat_add(acc.isum, wave_chain[CELLS].isum);
    if (wave_chain[CELLS].hit) begin
      fin.hit   = 1'b1;
      fin.exact = wave_chain[CELLS].exact;
    end
  end

  assign fin_done = wave_chain[CELLS].valid && wave_chain[CELLS].last;
  assign res_load = ((state == S_IDLE) && accept && (op != OP_QUERY)) ||
                    ((state == S_WAIT) && fin_done);

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      count      <= '0;
      peak       <= '0;
      m_tvalid   <= 1'b0;
      seed_valid <= 1'b0;
      row_cnt    <= '0;
    end else begin
      if (res_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      seed_valid <= (state == S_SCAN);
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            count <= cnt_next;
            peak  <= peak_next;
            if (op == OP_QUERY) begin
              state   <= S_SCAN;
              row_cnt <= '0;
            end
          end
        end
        S_SCAN: begin
          if (row_cnt == ROW_W'(ROWS - 1)) begin
            state <= S_WAIT;
          end else begin
            row_cnt <= row_cnt + ROW_W'(1);
          end
        end
        S_WAIT: begin
          if (fin_done) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    seed_last <= (row_cnt == ROW_W'(ROWS - 1));

    if (wave_chain[CELLS].valid) begin
      acc <= fin;
    end

    if (accept) begin
      if (do_write) begin
        last_begin <= pb;
      end
      q_begin   <= pb;
      q_end     <= pe;
      acc       <= '0;
      o_status  <= imm_status;
      o_exact   <= '0;
      o_osum    <= '0;
      o_isum    <= '0;
      o_max     <= peak_next;
      o_count   <= 13'(cnt_next);
    end else if (state == S_WAIT && fin_done) begin
      o_status  <= ST_OK;
      o_exact   <= fin.hit ? fin.exact : '0;
      o_osum    <= fin.osum;
      o_isum    <= fin.isum;
      o_max     <= peak;
      o_count   <= 13'(count);
    end
  end

  assign m_tdata = {1'b0, o_count, o_max, o_isum, o_osum, o_exact, o_status};

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(TABLE_DEPTH))
    else $error("record count beyond table depth");

  a_peak_empty: assert property (@(posedge clk) disable iff (rst)
    (count == '0) |-> (peak == '0))
    else $error("nonzero peak with empty table");

  a_busy_no_take: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> !s_tready)
    else $error("input taken during a query");

  a_wave_in_query: assert property (@(posedge clk) disable iff (rst)
    wave_chain[CELLS].valid |-> (state != S_IDLE))
    else $error("row result outside a query");

  a_result_slot_free: assert property (@(posedge clk) disable iff (rst)
    (state == S_WAIT && fin_done) |-> !m_tvalid)
    else $error("query result would overwrite a pending result");

  a_scan_count_stable: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN || state == S_WAIT) |=> $stable(count))
    else $error("count changed during a query");

endmodule

`default_nettype wire

>>> tb/sorted_interval_depth_lookup_tb.sv
// ----------------------------------------------------------------------------
// sorted_interval_depth_lookup_tb
// Self-checking bench for the junction table: append, clear and depth query.
// ----------------------------------------------------------------------------
// A directed table covers empty queries, ordering errors, duplicates, the
// position and depth extremes and the unused op code. One sequence loads a
// long run of maximum depths on one start and one end so that both sums
// saturate. Random sequences then build sorted runs and probe them, mixed
// with noise. Results are checked against a table model or a typed expectation.
// ----------------------------------------------------------------------------

module sorted_interval_depth_lookup_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import sidl_pkg::*;

  localparam int TABLE_ROWS = 4096;
  localparam int RANDOM_ITEMS = 240;
  localparam int SAT_ROWS = 260;
  localparam int FILL_ROWS = 280;
  localparam int HOLD_CYCLES = 300;
  localparam int TAIL_CYCLES = 200;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  typedef struct packed {
    logic [1:0] op;
    pos_t       start;
    pos_t       stop;
    depth_t     depth;
  } junction_t;

  typedef struct packed {
    logic [1:0]  status;
    depth_t      exact;
    sum_t        start_sum;
    sum_t        end_sum;
    depth_t      peak;
    logic [12:0] count;
  } result_t;

  typedef struct {
    junction_t item;
    bit        typed;
    result_t   res;
  } dir_row_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [87:0]  s_tdata = '0;
  logic [1:0]   s_tuser = '0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [127:0] m_tdata;

  // table model
  pos_t   row_start [TABLE_ROWS];
  pos_t   row_stop  [TABLE_ROWS];
  depth_t row_depth [TABLE_ROWS];
  int     rows_used = 0;
  depth_t peak_seen = '0;

  result_t lookup_results_q[$];
  int      items_sent = 0;
  int      results_seen = 0;
  int      mismatches = 0;
  int      quiet_cycles = 0;
  bit      fast_mode = 1'b0;

  sorted_interval_depth_lookup u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic sum_t sat_sum(input sum_t acc, input depth_t d);
    logic [32:0] s;
    s = {1'b0, acc} + {9'b0, d};
    return s[32] ? '1 : s[31:0];
  endfunction

  // Applies one operation to the model table and returns the result it yields.
  function automatic result_t apply_junction_op(input junction_t j);
    result_t r;
    r = '0;
    case (j.op)
      OP_CLEAR: begin
        rows_used = 0;
        peak_seen = '0;
      end
      OP_APPEND: begin
        // full takes priority over ordering
        if (rows_used == TABLE_ROWS) begin
          r.status = ST_FULL;
        end else if (rows_used != 0 && j.start < row_start[rows_used - 1]) begin
          r.status = ST_ORDER;
        end else begin
          row_start[rows_used] = j.start;
          row_stop[rows_used]  = j.stop;
          row_depth[rows_used] = j.depth;
          rows_used++;
          if (j.depth > peak_seen) peak_seen = j.depth;
        end
      end
      OP_QUERY: begin
        for (int i = 0; i < rows_used; i++) begin
          if (row_start[i] == j.start) begin
            r.start_sum = sat_sum(r.start_sum, row_depth[i]);
            if (row_stop[i] == j.stop) r.exact = row_depth[i];
          end
          if (row_stop[i] == j.stop) r.end_sum = sat_sum(r.end_sum, row_depth[i]);
        end
      end
      default: ;
    endcase
    r.peak  = peak_seen;
    r.count = 13'(rows_used);
    return r;
  endfunction

  function automatic dir_row_t row(input logic [1:0] op, input pos_t a, input pos_t b,
                                   input depth_t d, input bit typed, input logic [1:0] st,
                                   input depth_t pk, input logic [12:0] cnt);
    dir_row_t r;
    r.item  = '{op: op, start: a, stop: b, depth: d};
    r.typed = typed;
    r.res   = '0;
    r.res.status = st;
    r.res.peak   = pk;
    r.res.count  = cnt;
    return r;
  endfunction

  function automatic pos_t rand_pos();
    logic [31:0] v;
    v = $urandom;
    return v[30:0];
  endfunction

  function automatic depth_t rand_depth();
    logic [31:0] v;
    v = $urandom;
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return v[23:0];
    endcase
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (mismatches < 40)
      $display("[%0t] mismatch in %s: got 0x%0h, expected 0x%0h (result %0d)",
               $realtime, what, got, want, results_seen);
    mismatches++;
  endtask

  // One input transfer; the expectation is recorded on the accepting edge.
  task automatic transfer_item(input junction_t j, input bit typed, input result_t typed_res);
    result_t predicted;
    int gap;
    gap = fast_mode ? 0 : $urandom_range(0, 6);
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= j.op;
    s_tdata  <= {2'b00, j.depth, j.stop, j.start};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predicted = apply_junction_op(j);
    lookup_results_q.push_back(typed ? typed_res : predicted);
    items_sent++;
  endtask

  task automatic send(input logic [1:0] op, input pos_t a, input pos_t b, input depth_t d);
    transfer_item('{op: op, start: a, stop: b, depth: d}, 1'b0, '0);
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (lookup_results_q.size() != 0) @(posedge clk);
  endtask

  task automatic send_probe();
    int a, b;
    a = (rows_used == 0) ? 0 : $urandom_range(0, rows_used - 1);
    b = (rows_used == 0) ? 0 : $urandom_range(0, rows_used - 1);
    if (rows_used == 0) begin
      send(OP_QUERY, rand_pos(), rand_pos(), rand_depth());
    end else begin
      case ($urandom_range(0, 5))
        0, 1, 2: send(OP_QUERY, row_start[a], row_stop[a], rand_depth());
        3:       send(OP_QUERY, row_start[a], row_stop[b], rand_depth());
        4:       send(OP_QUERY, row_start[a], rand_pos(), rand_depth());
        default: send(OP_QUERY, rand_pos(), row_stop[b], rand_depth());
      endcase
    end
  endtask

  // Sorted run of appends with repeats, a few broken ones, then probes.
  task automatic build_and_probe();
    int n_add;
    logic [31:0] next;
    pos_t cur, stop_pick;
    if (rows_used == TABLE_ROWS || $urandom_range(0, 2) == 0)
      send(OP_CLEAR, rand_pos(), rand_pos(), rand_depth());
    if (rows_used != 0) begin
      cur = row_start[rows_used - 1];
    end else begin
      case ($urandom_range(0, 3))
        0:       cur = '0;
        1:       cur = 31'h7FFF_FFF0;
        default: cur = rand_pos();
      endcase
    end
    n_add = $urandom_range(1, 16);
    for (int i = 0; i < n_add; i++) begin
      if (cur != 0 && $urandom_range(0, 9) == 0) begin
        send(OP_APPEND, cur - 31'd1, rand_pos(), rand_depth());
      end else begin
        next = {1'b0, cur} + (($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 3));
        cur = next[31] ? '1 : next[30:0];
        // stops drawn from a small window so different starts share ends
        stop_pick = ($urandom_range(0, 7) == 0) ? rand_pos()
                                                : (cur & ~31'h7) + 31'($urandom_range(0, 5));
        send(OP_APPEND, cur, stop_pick, rand_depth());
      end
      if ($urandom_range(0, 4) == 0) send_probe();
    end
    repeat ($urandom_range(1, 4)) send_probe();
  endtask

  task automatic noise_burst();
    repeat ($urandom_range(1, 6))
      send(2'($urandom_range(0, 3)), rand_pos(), rand_pos(), rand_depth());
  endtask

  // Long run of maximum depths on one start and one end, so both sums
  // saturate, then a short tail of random depths on the next start and end.
  task automatic fill_table();
    depth_t d;
    send(OP_CLEAR, '0, '0, '0);
    for (int i = 0; i < FILL_ROWS; i++) begin
      fast_mode = (i % 64) < 32;
      d = (i < SAT_ROWS) ? '1 : rand_depth();
      send(OP_APPEND, 31'(1000 + i / SAT_ROWS), 31'(77 + i / SAT_ROWS), d);
    end
    fast_mode = 1'b0;
    send(OP_APPEND, 31'd2000, 31'd77, '1);
    send(OP_APPEND, 31'd0, 31'd0, 24'd5);
    send(OP_QUERY, 31'd1000, 31'd77, '0);
    send(OP_QUERY, 31'd1001, 31'd78, '0);
    send(OP_QUERY, 31'd1003, 31'd77, '0);
    send(OP_QUERY, 31'd5, 31'd79, '0);
    send(OP_UNUSED, '1, '1, '1);
  endtask

  // receiving side: random stalls, two long hold-offs, and the field checks
  initial begin : result_side
    result_t got, want;
    int stall;
    while (rst) @(posedge clk);
    forever begin
      stall = fast_mode ? 0 : $urandom_range(0, 6);
      if (results_seen == 40 || results_seen == 400) stall = HOLD_CYCLES;
      if (stall != 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      @(posedge clk);
      while (!m_tvalid) @(posedge clk);
      got.status    = m_tdata[1:0];
      got.exact     = m_tdata[25:2];
      got.start_sum = m_tdata[57:26];
      got.end_sum   = m_tdata[89:58];
      got.peak      = m_tdata[113:90];
      got.count     = m_tdata[126:114];
      if (lookup_results_q.size() == 0) begin
        report_mismatch("unexpected result (count)", got.count, '0);
      end else begin
        want = lookup_results_q.pop_front();
        if (got.status != want.status) report_mismatch("status", got.status, want.status);
        if (got.exact != want.exact) report_mismatch("exact_depth", got.exact, want.exact);
        if (got.start_sum != want.start_sum)
          report_mismatch("out_sum", got.start_sum, want.start_sum);
        if (got.end_sum != want.end_sum) report_mismatch("in_sum", got.end_sum, want.end_sum);
        if (got.peak != want.peak) report_mismatch("max_depth", got.peak, want.peak);
        if (got.count != want.count) report_mismatch("entry_count", got.count, want.count);
      end
      results_seen++;
    end
  end

  // cycles without any transfer on either side
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("[%0t] no transfer for %0d cycles", $realtime, WATCHDOG_LIMIT);
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin : stimulus
    dir_row_t dir_rows[$];
    int random_start;
    int pick;

    dir_rows.push_back(row(OP_QUERY, 31'd0, 31'd0, 24'd0, 1, ST_OK, 24'd0, 13'd0));
    dir_rows.push_back(row(OP_UNUSED, '1, '1, '1, 1, ST_OK, 24'd0, 13'd0));
    dir_rows.push_back(row(OP_APPEND, 31'd5, 31'd10, 24'h000100, 1, ST_OK, 24'h000100, 13'd1));
    dir_rows.push_back(row(OP_APPEND, 31'd4, 31'd10, 24'h000300, 1, ST_ORDER, 24'h000100,
                           13'd1));
    dir_rows.push_back(row(OP_APPEND, 31'd5, 31'd20, '1, 1, ST_OK, '1, 13'd2));
    dir_rows.push_back(row(OP_APPEND, 31'd5, 31'd10, 24'h000200, 1, ST_OK, '1, 13'd3));
    dir_rows.push_back(row(OP_APPEND, 31'd6, 31'd10, 24'h000055, 1, ST_OK, '1, 13'd4));
    // duplicate (start, end): the later record wins
    dir_rows.push_back(row(OP_QUERY, 31'd5, 31'd10, '0, 0, ST_OK, '0, '0));
    dir_rows.push_back(row(OP_QUERY, 31'd5, 31'd20, '1, 0, ST_OK, '0, '0));
    dir_rows.push_back(row(OP_QUERY, 31'd6, 31'd99, '0, 0, ST_OK, '0, '0));
    dir_rows.push_back(row(OP_QUERY, 31'd0, 31'd0, '0, 0, ST_OK, '0, '0));
    dir_rows.push_back(row(OP_APPEND, '1, 31'd0, 24'd0, 1, ST_OK, '1, 13'd5));
    dir_rows.push_back(row(OP_APPEND, 31'd0, '1, 24'd1, 1, ST_ORDER, '1, 13'd5));
    dir_rows.push_back(row(OP_QUERY, '1, 31'd0, '0, 0, ST_OK, '0, '0));
    dir_rows.push_back(row(OP_UNUSED, 31'd5, 31'd10, 24'h000123, 1, ST_OK, '1, 13'd5));
    dir_rows.push_back(row(OP_CLEAR, 31'd0, 31'd0, 24'd0, 1, ST_OK, 24'd0, 13'd0));
    dir_rows.push_back(row(OP_QUERY, 31'd5, 31'd10, '0, 1, ST_OK, 24'd0, 13'd0));
    dir_rows.push_back(row(OP_APPEND, 31'd0, '1, 24'h800000, 1, ST_OK, 24'h800000, 13'd1));
    dir_rows.push_back(row(OP_APPEND, 31'd0, '1, 24'h7FFFFF, 1, ST_OK, 24'h800000, 13'd2));
    dir_rows.push_back(row(OP_QUERY, 31'd0, '1, '0, 0, ST_OK, '0, '0));
    dir_rows.push_back(row(OP_CLEAR, '1, '1, '1, 1, ST_OK, 24'd0, 13'd0));

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_rows[k]) transfer_item(dir_rows[k].item, dir_rows[k].typed, dir_rows[k].res);
    drain();

    fill_table();
    drain();

    random_start = items_sent;
    while (items_sent - random_start < RANDOM_ITEMS) begin
      fast_mode = ($urandom_range(0, 4) == 0);
      pick = $urandom_range(0, 9);
      if (pick < 7) build_and_probe();
      else if (pick < 9) noise_burst();
      else drain();
    end
    fast_mode = 1'b0;

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (lookup_results_q.size() != 0)
      report_mismatch("results still awaited", lookup_results_q.size(), '0);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

>>> sim.f
hw/rtl/sidl_pkg.sv
hw/rtl/sidl_cell.sv
hw/rtl/sorted_interval_depth_lookup.sv
tb/sorted_interval_depth_lookup_tb.sv
